>>> rtl/lcabl_pkg.sv
// Shared types, constants and helpers of the LCA binary lifting engine.
package lcabl_pkg;

    // Vertex id and depth width (fixed by the field widths).
    localparam int ID_W    = 10;
    // Level number width; covers up to 16 lifting levels.
    localparam int LEVEL_W = 4;

    // Default sizes for the top-level parameters.
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_LEVELS       = 10;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Write request into the tables.
    typedef struct packed {
        logic                anc_we;
        logic                dep_we;
        logic [LEVEL_W-1:0]  level;
        logic [ID_W-1:0]     vertex;
        logic [ID_W-1:0]     anc_data;
        logic [ID_W-1:0]     dep_data;
    } tbl_wr_t;

    // Read request into the tables; data returns in the next cycle.
    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [ID_W-1:0]     anc_vertex;
        logic [ID_W-1:0]     dep_vertex;
    } tbl_rd_t;

    // Position of the highest set bit; zero input gives zero.
    function automatic logic [LEVEL_W-1:0] floor_log2(input logic [ID_W-1:0] v);
        logic [LEVEL_W-1:0] k;
        k = '0;
        for (int b = 0; b < ID_W; b++) begin
            if (v[b]) begin
                k = LEVEL_W'(b);
            end
        end
        return k;
    endfunction

endpackage

>>> rtl/lcabl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcabl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/lcabl_tables.sv
// Ancestor and depth stores with range checks and the post-reset clearing pass.
module lcabl_tables #(
    parameter int MAX_VERTICES = lcabl_pkg::DEF_MAX_VERTICES,
    parameter int LEVELS       = lcabl_pkg::DEF_LEVELS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lcabl_pkg::tbl_wr_t        wr,
    input  lcabl_pkg::tbl_rd_t        rd,
    output logic [lcabl_pkg::ID_W-1:0] anc_rdata,
    output logic [lcabl_pkg::ID_W-1:0] dep_rdata,
    output logic                      clearing
);

    localparam int IDX_W = $clog2(MAX_VERTICES);

    logic [IDX_W-1:0]               clear_cnt_reg;
    logic                           clearing_reg;
    logic [lcabl_pkg::LEVEL_W-1:0]  rd_level_reg;
    logic                           anc_ok_reg;
    logic                           dep_ok_reg;

    logic                           wr_ok;
    logic                           anc_ok_next;
    logic                           dep_ok_next;
    logic [IDX_W-1:0]               waddr;
    logic [lcabl_pkg::ID_W-1:0]     anc_wdata;
    logic [lcabl_pkg::ID_W-1:0]     dep_wdata;
    logic [lcabl_pkg::ID_W-1:0]     anc_q [LEVELS];
    logic [lcabl_pkg::ID_W-1:0]     dep_q;
    logic [lcabl_pkg::ID_W-1:0]     anc_sel;

    assign clearing = clearing_reg;

    // Range checks: ids past the store and levels past the table read as zero
    assign wr_ok       = 32'(wr.vertex) < MAX_VERTICES;
    assign anc_ok_next = (32'(rd.anc_vertex) < MAX_VERTICES) && (32'(rd.level) < LEVELS);
    assign dep_ok_next = 32'(rd.dep_vertex) < MAX_VERTICES;

    // Clearing pass owns the write port until every row is zero
    assign waddr     = clearing_reg ? clear_cnt_reg : IDX_W'(wr.vertex);
    assign anc_wdata = clearing_reg ? '0 : wr.anc_data;
    assign dep_wdata = clearing_reg ? '0 : wr.dep_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            clearing_reg  <= 1'b1;
            rd_level_reg  <= '0;
            anc_ok_reg    <= 1'b0;
            dep_ok_reg    <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clear_cnt_reg == IDX_W'(MAX_VERTICES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            rd_level_reg <= rd.level;
            anc_ok_reg   <= anc_ok_next;
            dep_ok_reg   <= dep_ok_next;
        end
    end

    // One RAM per lifting level, all read at the same vertex
    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        logic lvl_we;
        assign lvl_we = clearing_reg ||
                        (wr.anc_we && wr_ok && (wr.level == lcabl_pkg::LEVEL_W'(l)));
        lcabl_ram #(
            .WIDTH (lcabl_pkg::ID_W),
            .DEPTH (MAX_VERTICES)
        ) u_anc_ram (
            .clk   (clk),
            .we    (lvl_we),
            .waddr (waddr),
            .wdata (anc_wdata),
            .raddr (IDX_W'(rd.anc_vertex)),
            .rdata (anc_q[l])
        );
    end

    lcabl_ram #(
        .WIDTH (lcabl_pkg::ID_W),
        .DEPTH (MAX_VERTICES)
    ) u_dep_ram (
        .clk   (clk),
        .we    (clearing_reg || (wr.dep_we && wr_ok)),
        .waddr (waddr),
        .wdata (dep_wdata),
        .raddr (IDX_W'(rd.dep_vertex)),
        .rdata (dep_q)
    );

    // Level select on the registered read
    always_comb
    begin
        anc_sel = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (rd_level_reg == lcabl_pkg::LEVEL_W'(l))
            begin
                anc_sel = anc_q[l];
            end
        end
    end

    assign anc_rdata = anc_ok_reg ? anc_sel : '0;
    assign dep_rdata = dep_ok_reg ? dep_q : '0;

endmodule

>>> rtl/lca_binary_lifting_engine.sv
// Lowest common ancestor engine by binary lifting: sequencer over the lifting tables.
// Load: written as it is accepted, busy stays low. Build: three table accesses per entry
// on one read port, entries 2..n of levels 1..k, n the capped vertex count, k the top level.
// Query: depth reads and up to two lifting passes; the strobe follows.
// Reset clears both stores one row a cycle; busy is high meanwhile.
// The result strobe lasts one cycle and cannot be held off.
module lca_binary_lifting_engine #(
    parameter int MAX_VERTICES = lcabl_pkg::DEF_MAX_VERTICES,
    parameter int LEVELS       = lcabl_pkg::DEF_LEVELS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 command,
    input  logic [lcabl_pkg::ID_W-1:0] vertex_a,
    input  logic [lcabl_pkg::ID_W-1:0] vertex_b,
    input  logic [lcabl_pkg::ID_W-1:0] vertex_depth,
    input  logic                       config_write,
    input  logic [lcabl_pkg::ID_W-1:0] config_data,
    output logic                       result_valid,
    output logic [lcabl_pkg::ID_W-1:0] common_ancestor
);

    localparam int ID_W    = lcabl_pkg::ID_W;
    localparam int LEVEL_W = lcabl_pkg::LEVEL_W;
    // Depths and lift steps stay below 2**ID_W, so one carry bit is enough
    localparam int SUM_W   = ID_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_RDA,
        S_Q_RDB,
        S_Q_SWAP,
        S_Q_L1,
        S_Q_L1X,
        S_Q_L1D,
        S_Q_EQ,
        S_Q_L2A,
        S_Q_L2B,
        S_Q_L2C,
        S_Q_FIN,
        S_Q_OUT
    } state_t;

    state_t              state_reg;
    logic [ID_W-1:0]     vertex_count_reg;
    logic [ID_W-1:0]     x_reg;
    logic [ID_W-1:0]     y_reg;
    logic [ID_W-1:0]     dx_reg;
    logic [ID_W-1:0]     dy_reg;
    logic [ID_W-1:0]     ax_reg;
    logic [ID_W-1:0]     j_reg;
    logic [ID_W-1:0]     n_reg;
    logic [LEVEL_W-1:0]  lvl_reg;
    logic [LEVEL_W-1:0]  k_reg;
    logic                result_valid_reg;
    logic [ID_W-1:0]     common_ancestor_reg;

    lcabl_pkg::tbl_wr_t  wr;
    lcabl_pkg::tbl_rd_t  rd;
    logic [ID_W-1:0]     anc_rdata;
    logic [ID_W-1:0]     dep_rdata;
    logic                clearing;

    logic                accept;
    logic [ID_W-1:0]     n_cap;
    logic [LEVEL_W-1:0]  k_build;
    logic                swap;
    logic [ID_W-1:0]     d_hi;
    logic [ID_W-1:0]     d_lo;
    logic [ID_W-1:0]     d_diff;
    logic [SUM_W-1:0]    lift_need;
    logic                lift_take;

    // Top level number capped at the table height
    function automatic logic [LEVEL_W-1:0] cap_level(input logic [ID_W-1:0] v);
        logic [LEVEL_W-1:0] k;
        k = lcabl_pkg::floor_log2(v);
        if (32'(k) > LEVELS - 1)
        begin
            k = LEVEL_W'(LEVELS - 1);
        end
        return k;
    endfunction

    assign busy            = (state_reg != S_IDLE) || clearing;
    assign accept          = start && !busy;
    assign result_valid    = result_valid_reg;
    assign common_ancestor = common_ancestor_reg;

    // Build range: vertex count capped below the store size
    assign n_cap   = (32'(vertex_count_reg) > MAX_VERTICES - 1) ?
                     ID_W'(MAX_VERTICES - 1) : vertex_count_reg;
    assign k_build = cap_level(n_cap);

    // Depth ordering of the two query vertices
    assign swap   = dx_reg < dep_rdata;
    assign d_hi   = swap ? dep_rdata : dx_reg;
    assign d_lo   = swap ? dx_reg : dep_rdata;
    assign d_diff = d_hi - d_lo;

    // Lift test: depth(x) - 2**i >= depth(y)
    assign lift_need = SUM_W'(dy_reg) + (SUM_W'(1) << lvl_reg);
    assign lift_take = SUM_W'(dx_reg) >= lift_need;

    // Table read and write requests
    always_comb
    begin
        wr = '0;
        rd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (command == lcabl_pkg::CMD_LOAD) && (vertex_a != '0))
                begin
                    wr.anc_we   = 1'b1;
                    wr.dep_we   = 1'b1;
                    wr.level    = '0;
                    wr.vertex   = vertex_a;
                    wr.anc_data = (vertex_a == ID_W'(1)) ? '0 : vertex_b;
                    wr.dep_data = vertex_depth;
                end
            end
            S_B_RD1:
            begin
                rd.level      = lvl_reg - 1'b1;
                rd.anc_vertex = j_reg;
            end
            S_B_RD2:
            begin
                rd.level      = lvl_reg - 1'b1;
                rd.anc_vertex = anc_rdata;
            end
            S_B_WR:
            begin
                wr.anc_we   = 1'b1;
                wr.level    = lvl_reg;
                wr.vertex   = j_reg;
                wr.anc_data = anc_rdata;
            end
            S_Q_RDA:
            begin
                rd.dep_vertex = x_reg;
            end
            S_Q_RDB:
            begin
                rd.dep_vertex = y_reg;
            end
            S_Q_L1:
            begin
                rd.level      = lvl_reg;
                rd.anc_vertex = x_reg;
            end
            S_Q_L1X:
            begin
                rd.dep_vertex = anc_rdata;
            end
            S_Q_L2A:
            begin
                rd.level      = lvl_reg;
                rd.anc_vertex = x_reg;
            end
            S_Q_L2B:
            begin
                rd.level      = lvl_reg;
                rd.anc_vertex = y_reg;
            end
            S_Q_FIN:
            begin
                rd.level      = '0;
                rd.anc_vertex = x_reg;
            end
            S_Q_SWAP, S_Q_L1D, S_Q_EQ, S_Q_L2C, S_Q_OUT:
            begin
                rd = '0;
            end
            default:
            begin
                rd = '0;
            end
        endcase
    end

    // Sequencer, config register and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            vertex_count_reg    <= ID_W'(1);
            result_valid_reg    <= 1'b0;
            common_ancestor_reg <= '0;
            x_reg               <= '0;
            y_reg               <= '0;
            dx_reg              <= '0;
            dy_reg              <= '0;
            ax_reg              <= '0;
            j_reg               <= '0;
            n_reg               <= '0;
            lvl_reg             <= '0;
            k_reg               <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (config_write)
            begin
                vertex_count_reg <= config_data;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg <= vertex_a;
                        y_reg <= vertex_b;
                        if (command == lcabl_pkg::CMD_BUILD)
                        begin
                            if (k_build != '0)
                            begin
                                n_reg     <= n_cap;
                                k_reg     <= k_build;
                                lvl_reg   <= LEVEL_W'(1);
                                j_reg     <= ID_W'(2);
                                state_reg <= S_B_RD1;
                            end
                        end
                        else if (command == lcabl_pkg::CMD_QUERY)
                        begin
                            state_reg <= S_Q_RDA;
                        end
                    end
                end

                // Build: anc[l][j] = anc[l-1][anc[l-1][j]]
                S_B_RD1:
                begin
                    state_reg <= S_B_RD2;
                end
                S_B_RD2:
                begin
                    state_reg <= S_B_WR;
                end
                S_B_WR:
                begin
                    if (j_reg == n_reg)
                    begin
                        if (lvl_reg == k_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            lvl_reg   <= lvl_reg + 1'b1;
                            j_reg     <= ID_W'(2);
                            state_reg <= S_B_RD1;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_B_RD1;
                    end
                end

                // Query: fetch both depths, deeper vertex goes to x
                S_Q_RDA:
                begin
                    state_reg <= S_Q_RDB;
                end
                S_Q_RDB:
                begin
                    dx_reg    <= dep_rdata;
                    state_reg <= S_Q_SWAP;
                end
                S_Q_SWAP:
                begin
                    if (swap)
                    begin
                        x_reg <= y_reg;
                        y_reg <= x_reg;
                    end
                    dx_reg  <= d_hi;
                    dy_reg  <= d_lo;
                    lvl_reg <= cap_level(d_diff);
                    if (d_diff == '0)
                    begin
                        state_reg <= S_Q_EQ;
                    end
                    else
                    begin
                        state_reg <= S_Q_L1;
                    end
                end

                // First pass: lift x to y's depth, re-reading depth after each hop
                S_Q_L1:
                begin
                    if (lift_take)
                    begin
                        state_reg <= S_Q_L1X;
                    end
                    else if (lvl_reg == '0)
                    begin
                        state_reg <= S_Q_EQ;
                    end
                    else
                    begin
                        lvl_reg <= lvl_reg - 1'b1;
                    end
                end
                S_Q_L1X:
                begin
                    x_reg     <= anc_rdata;
                    state_reg <= S_Q_L1D;
                end
                S_Q_L1D:
                begin
                    dx_reg <= dep_rdata;
                    if (lvl_reg == '0)
                    begin
                        state_reg <= S_Q_EQ;
                    end
                    else
                    begin
                        lvl_reg   <= lvl_reg - 1'b1;
                        state_reg <= S_Q_L1;
                    end
                end

                S_Q_EQ:
                begin
                    if (x_reg == y_reg)
                    begin
                        common_ancestor_reg <= x_reg;
                        result_valid_reg    <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                    else if (dx_reg == '0)
                    begin
                        state_reg <= S_Q_FIN;
                    end
                    else
                    begin
                        lvl_reg   <= cap_level(dx_reg);
                        state_reg <= S_Q_L2A;
                    end
                end

                // Second pass: lift both while their ancestors differ
                S_Q_L2A:
                begin
                    state_reg <= S_Q_L2B;
                end
                S_Q_L2B:
                begin
                    ax_reg    <= anc_rdata;
                    state_reg <= S_Q_L2C;
                end
                S_Q_L2C:
                begin
                    if (ax_reg != anc_rdata)
                    begin
                        x_reg <= ax_reg;
                        y_reg <= anc_rdata;
                    end
                    if (lvl_reg == '0)
                    begin
                        state_reg <= S_Q_FIN;
                    end
                    else
                    begin
                        lvl_reg   <= lvl_reg - 1'b1;
                        state_reg <= S_Q_L2A;
                    end
                end

                // Parent of x is the answer
                S_Q_FIN:
                begin
                    state_reg <= S_Q_OUT;
                end
                S_Q_OUT:
                begin
                    common_ancestor_reg <= anc_rdata;
                    result_valid_reg    <= 1'b1;
                    state_reg           <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    lcabl_tables #(
        .MAX_VERTICES (MAX_VERTICES),
        .LEVELS       (LEVELS)
    ) u_tables (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd        (rd),
        .anc_rdata (anc_rdata),
        .dep_rdata (dep_rdata),
        .clearing  (clearing)
    );

endmodule

>>> bench/tb_lca_binary_lifting_engine.sv
// Self-checking testbench for the LCA binary lifting engine: tree stimulus, predictor, checker.
`timescale 1ns / 1ps

module tb_lca_binary_lifting_engine;

    localparam int ID_W    = lcabl_pkg::ID_W;
    localparam int NVERT   = lcabl_pkg::DEF_MAX_VERTICES;
    localparam int NLEVEL  = lcabl_pkg::DEF_LEVELS;
    localparam int ITEM_TARGET = 1850;

    typedef struct {
        lcabl_pkg::cmd_t cmd;
        logic [ID_W-1:0] va;
        logic [ID_W-1:0] vb;
        logic [ID_W-1:0] vd;
    } lca_item_t;

    // DUT signals
    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            start        = 1'b0;
    logic            busy;
    logic [1:0]      command      = '0;
    logic [ID_W-1:0] vertex_a     = '0;
    logic [ID_W-1:0] vertex_b     = '0;
    logic [ID_W-1:0] vertex_depth = '0;
    logic            config_write = 1'b0;
    logic [ID_W-1:0] config_data  = '0;
    logic            result_valid;
    logic [ID_W-1:0] common_ancestor;

    // Predictor state
    logic [ID_W-1:0] anc_mem [NLEVEL][NVERT];
    logic [ID_W-1:0] dep_mem [NVERT];
    int              model_vcount;

    // Stimulus and scoreboard
    lca_item_t       pending_items[$];
    lca_item_t       cur_item;
    logic [ID_W-1:0] lca_expected[$];
    logic [ID_W-1:0] want_lca;
    int              gen_depth [NVERT];
    int              items_queued   = 0;
    int              items_accepted = 0;
    int              items_counted  = 0;
    int              send_idle_pct  = 0;
    int              error_count    = 0;

    lca_binary_lifting_engine uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .vertex_depth    (vertex_depth),
        .config_write    (config_write),
        .config_data     (config_data),
        .result_valid    (result_valid),
        .common_ancestor (common_ancestor)
    );

    always #10 clk = ~clk;

    // floor(log2 v) capped at the top level; -1 when v <= 0
    function automatic int lift_level(input int v);
        int k;
        k = -1;
        while (v > 0)
        begin
            k = k + 1;
            v = v >> 1;
        end
        if (k > NLEVEL - 1)
            k = NLEVEL - 1;
        return k;
    endfunction

    // Fill levels 1..k from the level below for vertices 2..vertex_count
    function automatic void build_lifting();
        int n;
        int k;
        n = model_vcount;
        k = lift_level(n);
        for (int i = 1; i <= k; i++)
            for (int j = 2; j <= n; j++)
                anc_mem[i][j] = anc_mem[i-1][anc_mem[i-1][j]];
    endfunction

    // Lowest common ancestor by lifting over the current tables
    function automatic logic [ID_W-1:0] predict_lca(input logic [ID_W-1:0] qa,
                                                    input logic [ID_W-1:0] qb);
        logic [ID_W-1:0] x;
        logic [ID_W-1:0] y;
        logic [ID_W-1:0] t;
        logic [ID_W-1:0] ax;
        logic [ID_W-1:0] ay;
        int              k;
        x = qa;
        y = qb;
        if (dep_mem[x] < dep_mem[y])
        begin
            t = x;
            x = y;
            y = t;
        end
        // bring the deeper vertex up to equal depth
        k = lift_level(int'(dep_mem[x]) - int'(dep_mem[y]));
        for (int i = k; i >= 0; i--)
            if (int'(dep_mem[x]) - (1 << i) >= int'(dep_mem[y]))
                x = anc_mem[i][x];
        if (x == y)
            return x;
        // lift both while the ancestors differ
        k = lift_level(int'(dep_mem[x]));
        for (int i = k; i >= 0; i--)
        begin
            ax = anc_mem[i][x];
            ay = anc_mem[i][y];
            if (ax != ay)
            begin
                x = ax;
                y = ay;
            end
        end
        return anc_mem[0][x];
    endfunction

    // Apply one accepted command to the predictor
    function automatic void step_model(input lca_item_t it);
        case (it.cmd)
            lcabl_pkg::CMD_LOAD:
                if (it.va != ID_W'(0))
                begin
                    dep_mem[it.va]    = it.vd;
                    anc_mem[0][it.va] = (it.va == ID_W'(1)) ? ID_W'(0) : it.vb;
                end
            lcabl_pkg::CMD_BUILD: build_lifting();
            lcabl_pkg::CMD_QUERY: lca_expected = {lca_expected, predict_lca(it.va, it.vb)};
            default: ;
        endcase
    endfunction

    // Driver: one transfer per edge with start high and busy low
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                step_model(cur_item);
                items_accepted++;
            end
            if (!start || !busy)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_item     = pending_items.pop_front();
                    start        <= 1'b1;
                    command      <= cur_item.cmd;
                    vertex_a     <= cur_item.va;
                    vertex_b     <= cur_item.vb;
                    vertex_depth <= cur_item.vd;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, check each strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (lca_expected.size() == 0)
            begin
                $error("unexpected result transfer: common_ancestor actual %0d", common_ancestor);
                error_count++;
            end
            else
            begin
                want_lca = lca_expected.pop_front();
                if (common_ancestor !== want_lca)
                begin
                    $error("common_ancestor mismatch: expected %0d, actual %0d",
                           want_lca, common_ancestor);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_item(input lcabl_pkg::cmd_t c, input int a, input int b, input int d);
        lca_item_t it;
        it.cmd = c;
        it.va  = ID_W'(a);
        it.vb  = ID_W'(b);
        it.vd  = ID_W'(d);
        pending_items = {pending_items, it};
        items_queued++;
        if (!(c == lcabl_pkg::CMD_NONE || (c == lcabl_pkg::CMD_LOAD && it.va == ID_W'(0))))
            items_counted++;
    endtask

    // Occasional junk: wild queries, unused command, ignored or corrupting loads
    task automatic queue_noise(input int n);
        int r;
        int ids;
        ids = (n < 1) ? 1 : n;
        r = $urandom_range(0, 99);
        if (r < 30)
            queue_item(lcabl_pkg::CMD_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023));
        else if (r < 55)
            queue_item(lcabl_pkg::CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023));
        else if (r < 80)
            queue_item(lcabl_pkg::CMD_LOAD, 0, $urandom_range(0, 1023),
                       $urandom_range(0, 1023));
        else
            queue_item(lcabl_pkg::CMD_LOAD, $urandom_range(1, ids), $urandom_range(0, 1023),
                       $urandom_range(0, 1022));
    endtask

    // Random rooted tree over ids 1..n; lossy drops some loads
    task automatic queue_tree(input int n, input int chain_pct, input bit lossy);
        int v;
        int p;
        gen_depth[1] = 0;
        queue_item(lcabl_pkg::CMD_LOAD, 1, $urandom_range(0, 1023), 0);
        for (v = 2; v <= n; v++)
        begin
            if ($urandom_range(0, 99) < chain_pct)
                p = v - 1;
            else
                p = $urandom_range(1, v - 1);
            gen_depth[v] = gen_depth[p] + 1;
            if (!(lossy && $urandom_range(0, 99) < 15))
                queue_item(lcabl_pkg::CMD_LOAD, v, p, gen_depth[v]);
            if ($urandom_range(0, 99) < 4)
                queue_noise(n);
        end
    endtask

    // Wait until every transfer is done, every result is in and the engine is free
    task automatic wait_idle();
        do
            @(posedge clk);
        while (items_accepted != items_queued || lca_expected.size() != 0);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_vertex_count(input int v);
        @(posedge clk);
        config_write <= 1'b1;
        config_data  <= ID_W'(v);
        model_vcount = v;
        @(posedge clk);
        config_write <= 1'b0;
    endtask

    // One tree: configure, load, build (most of the time), query
    task automatic run_phase(input int n, input int idle_pct);
        int nq;
        int ids;
        wait_idle();
        write_vertex_count(n);
        send_idle_pct = idle_pct;
        queue_tree(n, (n > 500) ? 92 : 50, $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) != 0)
            queue_item(lcabl_pkg::CMD_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023));
        nq  = (n > 500) ? 120 : 10 + n / 2;
        ids = (n < 1) ? 1 : n;
        repeat (nq)
        begin
            if ($urandom_range(0, 99) < 12)
                queue_noise(n);
            else
                queue_item(lcabl_pkg::CMD_QUERY, $urandom_range(1, ids), $urandom_range(1, ids),
                           $urandom_range(0, 1022));
        end
    endtask

    // Stimulus
    initial
    begin
        int idle_plan [4];
        int phase_no;
        int n;
        int r;
        // no idling, sender idle, receiver phase (cannot stall), both
        idle_plan = '{0, 59, 0, 6};
        phase_no  = 0;
        for (int i = 0; i < NLEVEL; i++)
            for (int j = 0; j < NVERT; j++)
                anc_mem[i][j] = '0;
        for (int j = 0; j < NVERT; j++)
            dep_mem[j] = '0;
        model_vcount = 1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty tables, ignored loads, root parent forced to none, unused command
        queue_item(lcabl_pkg::CMD_QUERY, 0, 0, 0);
        queue_item(lcabl_pkg::CMD_QUERY, 1023, 1, 1022);
        queue_item(lcabl_pkg::CMD_LOAD, 0, 7, 9);
        queue_item(lcabl_pkg::CMD_LOAD, 1, 1023, 0);
        queue_item(lcabl_pkg::CMD_NONE, 1023, 1023, 1023);
        queue_item(lcabl_pkg::CMD_BUILD, 0, 0, 0);
        queue_item(lcabl_pkg::CMD_QUERY, 1, 1, 0);

        // small known tree
        wait_idle();
        write_vertex_count(8);
        queue_item(lcabl_pkg::CMD_LOAD, 2, 1, 1);
        queue_item(lcabl_pkg::CMD_LOAD, 3, 1, 1);
        queue_item(lcabl_pkg::CMD_LOAD, 4, 2, 2);
        queue_item(lcabl_pkg::CMD_LOAD, 5, 2, 2);
        queue_item(lcabl_pkg::CMD_LOAD, 6, 4, 3);
        queue_item(lcabl_pkg::CMD_LOAD, 7, 6, 4);
        queue_item(lcabl_pkg::CMD_LOAD, 8, 3, 2);
        queue_item(lcabl_pkg::CMD_BUILD, 0, 0, 0);
        queue_item(lcabl_pkg::CMD_QUERY, 7, 5, 0);
        queue_item(lcabl_pkg::CMD_QUERY, 8, 7, 0);
        queue_item(lcabl_pkg::CMD_QUERY, 6, 7, 0);
        queue_item(lcabl_pkg::CMD_QUERY, 7, 7, 0);
        queue_item(lcabl_pkg::CMD_QUERY, 1, 7, 0);
        queue_item(lcabl_pkg::CMD_QUERY, 0, 5, 0);
        // self-looped vertex at maximum depth, outside the built range
        queue_item(lcabl_pkg::CMD_LOAD, 1023, 1023, 1022);
        queue_item(lcabl_pkg::CMD_QUERY, 1023, 4, 0);

        // random trees; vertex count zero first, full size once
        while (items_counted < ITEM_TARGET)
        begin
            if (phase_no == 0)
                n = 0;
            else if (phase_no == 2)
                n = 1023;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    n = $urandom_range(0, 1);
                else if (r < 20)
                    n = $urandom_range(49, 160);
                else
                    n = $urandom_range(2, 48);
            end
            run_phase(n, idle_plan[phase_no % 4]);
            phase_no++;
        end

        wait_idle();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
